@@ rtl/nmea_gga_rmc_field_parser_top_assert.svh @@
// assertion macros for the nmea field parser
`ifndef NMEA_GGA_RMC_FIELD_PARSER_TOP_ASSERT_SVH
`define NMEA_GGA_RMC_FIELD_PARSER_TOP_ASSERT_SVH

`ifndef SYNTH

// property holds on every clock edge outside reset
`define NGRP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ngrp assertion failed");

// condition never occurs outside reset
`define NGRP_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ngrp forbidden condition");

`else

`define NGRP_ASSERT(lbl, clk, rstn, prop)
`define NGRP_NEVER(lbl, clk, rstn, cond)

`endif

`endif

@@ rtl/ngrp_pkg.sv @@
package ngrp_pkg;

  // field codes of a result item
  localparam logic [3:0] FC_TIME   = 4'd0;
  localparam logic [3:0] FC_LAT    = 4'd1;
  localparam logic [3:0] FC_NS     = 4'd2;
  localparam logic [3:0] FC_LON    = 4'd3;
  localparam logic [3:0] FC_EW     = 4'd4;
  localparam logic [3:0] FC_FIX    = 4'd5;
  localparam logic [3:0] FC_SATS   = 4'd6;
  localparam logic [3:0] FC_ALT    = 4'd7;
  localparam logic [3:0] FC_VALID  = 4'd8;
  localparam logic [3:0] FC_SPEED  = 4'd9;
  localparam logic [3:0] FC_COURSE = 4'd10;
  localparam logic [3:0] FC_DATE   = 4'd11;
  localparam logic [3:0] FC_NONE   = 4'd15;

  // fixed accumulator widths (nine integer and seven fraction digits at most)
  localparam int IntW  = 30;
  localparam int HiW   = 24;
  localparam int FracW = 24;
  localparam int MilW  = 10;
  localparam int ValW  = 48;

  // term as handed from front to back
  typedef struct packed {
    logic [3:0]       code;
    logic             kind;
    logic [IntW-1:0]  int_bin;
    logic [HiW-1:0]   hi_bin;
    logic [6:0]       low2;
    logic [6:0]       mid2;
    logic [6:0]       high2;
    logic [FracW-1:0] frac_raw;
    logic [FracW-1:0] frac_e7;
    logic [MilW-1:0]  frac_milli;
    logic             flag;
    logic             minus;
    logic [11:0]      seen;
  } rec_t;

  // powers of ten for elaboration-time constants
  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

endpackage

@@ rtl/ngrp_front.sv @@
module ngrp_front import ngrp_pkg::*; #(
  parameter int TERM_LIMIT  = 20,
  parameter int INT_DIGITS  = 9,
  parameter int FRAC_DIGITS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [7:0]  char_in_i,
  input  logic [11:0] req_mask_i,
  output logic        push_o,
  output rec_t        rec_o
);

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChS      = 8'h53;
  localparam logic [7:0] ChW      = 8'h57;

  localparam logic [1:0] KindGga  = 2'd0;
  localparam logic [1:0] KindRmc  = 2'd1;
  localparam logic [1:0] KindNone = 2'd2;

  localparam logic [7:0] HdrGga [6] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
  localparam logic [7:0] HdrRmc [6] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

  localparam logic [IntW-1:0] IntLim = IntW'(pow10(INT_DIGITS) - 1);
  localparam logic [IntW-1:0] IntThr = IntW'(pow10(INT_DIGITS - 1));
  localparam logic [HiW-1:0]  HiLim  = HiW'(pow10(INT_DIGITS - 2) - 1);

  // fraction digit weights by position, for 1e-7 and 1e-3 scaling
  localparam logic [FracW-1:0] E7W [8] = '{24'd1000000, 24'd100000, 24'd10000,
    24'd1000, 24'd100, 24'd10, 24'd1, 24'd0};
  localparam logic [MilW-1:0] MilWt [8] = '{10'd100, 10'd10, 10'd1, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0};

  typedef struct packed {
    logic [4:0]       len;
    logic [7:0]       first;
    logic             hm_gga;
    logic             hm_rmc;
    logic             closed;
    logic [IntW-1:0]  int_bin;
    logic [HiW-1:0]   hi_bin;
    logic [5:0][3:0]  dig;
    logic [FracW-1:0] frac_raw;
    logic [FracW-1:0] frac_e7;
    logic [MilW-1:0]  frac_milli;
    logic [2:0]       fcnt;
    logic             after_dot;
    logic             minus;
  } term_t;

  localparam term_t TermFresh = '{len: '0, first: '0, hm_gga: 1'b1, hm_rmc: 1'b1,
    closed: 1'b0, int_bin: '0, hi_bin: '0, dig: '0, frac_raw: '0, frac_e7: '0,
    frac_milli: '0, fcnt: '0, after_dot: 1'b0, minus: 1'b0};

  logic        in_sent_q, in_sent_d;
  logic [4:0]  idx_q, idx_d;
  logic [1:0]  kind_q, kind_d;
  logic [11:0] seen_q, seen_d;
  term_t       term_q, term_d;

  // term index to field code
  function automatic logic [3:0] field_of(input logic [1:0] kind, input logic [4:0] idx);
    logic [3:0] c;
    c = FC_NONE;
    if (kind == KindGga) begin
      case (idx)
        5'd1:    c = FC_TIME;
        5'd2:    c = FC_LAT;
        5'd3:    c = FC_NS;
        5'd4:    c = FC_LON;
        5'd5:    c = FC_EW;
        5'd6:    c = FC_FIX;
        5'd7:    c = FC_SATS;
        5'd9:    c = FC_ALT;
        default: c = FC_NONE;
      endcase
    end else if (kind == KindRmc) begin
      case (idx)
        5'd2:    c = FC_VALID;
        5'd7:    c = FC_SPEED;
        5'd8:    c = FC_COURSE;
        5'd9:    c = FC_DATE;
        default: c = FC_NONE;
      endcase
    end
    return c;
  endfunction

  // per-character sentence and term handling
  always_comb begin
    logic       digit;
    logic [3:0] d;
    logic [3:0] code;
    in_sent_d = in_sent_q;
    idx_d     = idx_q;
    kind_d    = kind_q;
    term_d    = term_q;
    seen_d    = seen_q;
    push_o    = 1'b0;
    rec_o     = '0;
    digit     = (char_in_i >= ChZero) && (char_in_i <= ChNine);
    d         = char_in_i[3:0];
    code      = field_of(kind_q, idx_q);
    if (acc_i) begin
      if (seen_q == req_mask_i) seen_d = '0;
      if (char_in_i == ChDollar) begin
        in_sent_d = 1'b1;
        idx_d     = '0;
        term_d    = TermFresh;
      end
      if (in_sent_d) begin
        if (char_in_i == ChComma || char_in_i == ChStar) begin
          // close the term
          if (idx_q == 5'd0) begin
            if (term_d.len >= 5'd6 && term_d.hm_gga) kind_d = KindGga;
            else if (term_d.len >= 5'd6 && term_d.hm_rmc) kind_d = KindRmc;
            else begin
              kind_d    = KindNone;
              in_sent_d = 1'b0;
            end
          end else if (code != FC_NONE) begin
            push_o           = 1'b1;
            seen_d           = seen_d | (12'd1 << code);
            rec_o.code       = code;
            rec_o.kind       = kind_q[0];
            rec_o.int_bin    = term_d.int_bin;
            rec_o.hi_bin     = term_d.hi_bin;
            rec_o.low2       = 7'(term_d.dig[1]) * 7'd10 + 7'(term_d.dig[0]);
            rec_o.mid2       = 7'(term_d.dig[3]) * 7'd10 + 7'(term_d.dig[2]);
            rec_o.high2      = 7'(term_d.dig[5]) * 7'd10 + 7'(term_d.dig[4]);
            rec_o.frac_raw   = term_d.frac_raw;
            rec_o.frac_e7    = term_d.frac_e7;
            rec_o.frac_milli = term_d.frac_milli;
            rec_o.minus      = term_d.minus;
            rec_o.seen       = seen_d;
            rec_o.flag       = ((code == FC_NS) && (term_d.first == ChS)) ||
                               ((code == FC_EW) && (term_d.first == ChW)) ||
                               ((code == FC_VALID) && (term_d.first == ChA));
          end
          if (char_in_i == ChComma) begin
            if (idx_q != 5'd31) idx_d = idx_q + 5'd1;
          end else begin
            in_sent_d = 1'b0;
            idx_d     = '0;
          end
          term_d = TermFresh;
        end else if (char_in_i == ChCr) begin
          term_d = TermFresh;
        end else if (char_in_i == ChLf) begin
          in_sent_d = 1'b0;
          idx_d     = '0;
          term_d    = TermFresh;
        end else if (term_d.len < 5'(TERM_LIMIT)) begin
          // take one character of the term
          if (term_d.len == 5'd0) term_d.first = char_in_i;
          if (idx_d == 5'd0 && term_d.len < 5'd6) begin
            if (char_in_i != HdrGga[term_d.len[2:0]]) term_d.hm_gga = 1'b0;
            if (char_in_i != HdrRmc[term_d.len[2:0]]) term_d.hm_rmc = 1'b0;
          end
          if (term_d.len == 5'd0 && char_in_i == ChMinus && kind_q == KindGga &&
              idx_d == 5'd9) begin
            term_d.minus = 1'b1;
          end else if (!term_d.closed) begin
            if (!term_d.after_dot) begin
              if (digit) begin
                if (term_d.int_bin >= IntThr) begin
                  term_d.int_bin = IntLim;
                  term_d.hi_bin  = HiLim;
                  term_d.dig     = {6{4'd9}};
                end else begin
                  term_d.int_bin = IntW'(term_d.int_bin * 4'd10) + IntW'(d);
                  term_d.hi_bin  = HiW'(term_d.hi_bin * 4'd10) + HiW'(term_d.dig[1]);
                  term_d.dig     = {term_d.dig[4:0], d};
                end
              end else begin
                term_d.after_dot = 1'b1;
              end
            end else if (digit) begin
              if (term_d.fcnt < 3'(FRAC_DIGITS)) begin
                term_d.frac_raw   = FracW'(term_d.frac_raw * 4'd10) + FracW'(d);
                term_d.frac_e7    = term_d.frac_e7 + FracW'(E7W[term_d.fcnt] * d);
                term_d.frac_milli = term_d.frac_milli + MilW'(MilWt[term_d.fcnt] * d);
                term_d.fcnt       = term_d.fcnt + 3'd1;
              end
            end else begin
              term_d.closed = 1'b1;
            end
          end
          term_d.len = term_d.len + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0;
      idx_q     <= '0;
      kind_q    <= KindNone;
      seen_q    <= '0;
      term_q    <= '0;
    end else begin
      in_sent_q <= in_sent_d;
      idx_q     <= idx_d;
      kind_q    <= kind_d;
      seen_q    <= seen_d;
      term_q    <= term_d;
    end
  end

endmodule

@@ rtl/ngrp_queue.sv @@
module ngrp_queue import ngrp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output rec_t data_o
);

  localparam int Depth = 4;
  localparam int AW    = $clog2(Depth);

  rec_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign data_o  = mem_q[rd_q];

  // pointer and fill count
  always_comb begin
    wr_d  = push_i ? wr_q + AW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ rtl/ngrp_back.sv @@
module ngrp_back import ngrp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  rec_t                   q_data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [3:0]             field_code_o,
  output logic                   sentence_kind_o,
  output logic signed [ValW-1:0] fixed_value_o,
  output logic [6:0]             part_high_o,
  output logic [6:0]             part_mid_o,
  output logic [6:0]             part_low_o,
  output logic [23:0]            sub_second_o,
  output logic                   flag_bit_o,
  output logic [11:0]            fields_seen_o
);

  // reciprocal of 15 scaled by 2^34, exact for 28-bit dividends
  localparam logic [30:0] Recip15 = 31'd1145324613;
  localparam logic [23:0] E7      = 24'd10000000;

  typedef struct packed {
    logic [3:0]       code;
    logic             kind;
    logic [6:0]       low2;
    logic [6:0]       mid2;
    logic [6:0]       high2;
    logic [FracW-1:0] frac_raw;
    logic             flag;
    logic             minus;
    logic [11:0]      seen;
    logic [IntW-1:0]  int_bin;
    logic [ValW-1:0]  deg_e7;
    logic [ValW-1:0]  milli;
  } common_t;

  logic            v1_q, v2_q, v3_q;
  logic            adv;
  common_t         s1_q, s2_q;
  logic [29:0]     min_e7_q;
  logic [23:0]     min_div_q;
  logic [ValW-1:0] lat_q, lat_d, lon_q, lon_d;
  logic [58:0]     div_prod;
  logic [30:0]     min_sum;
  logic [ValW-1:0] val_d;
  logic [6:0]      hi_d, mid_d, lo_d;
  logic [23:0]     sub_d;

  assign adv         = !v3_q || !out_stall_i;
  assign pop_o       = adv && q_valid_i;
  assign out_valid_o = v3_q;
  assign min_sum     = 31'(q_data_i.low2) * 31'(E7) + 31'(q_data_i.frac_e7);
  assign div_prod    = 59'(min_e7_q[29:2]) * 59'(Recip15);

  // pipeline occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      lat_q <= '0;
      lon_q <= '0;
    end else if (adv) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v2_q) begin
        lat_q <= lat_d;
        lon_q <= lon_d;
      end
    end
  end

  // stage 1: products; stage 2: minutes over 60
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.code     <= q_data_i.code;
      s1_q.kind     <= q_data_i.kind;
      s1_q.low2     <= q_data_i.low2;
      s1_q.mid2     <= q_data_i.mid2;
      s1_q.high2    <= q_data_i.high2;
      s1_q.frac_raw <= q_data_i.frac_raw;
      s1_q.flag     <= q_data_i.flag;
      s1_q.minus    <= q_data_i.minus;
      s1_q.seen     <= q_data_i.seen;
      s1_q.int_bin  <= q_data_i.int_bin;
      s1_q.deg_e7   <= ValW'(q_data_i.hi_bin) * ValW'(E7);
      s1_q.milli    <= ValW'(q_data_i.int_bin) * ValW'(10'd1000) +
                       ValW'(q_data_i.frac_milli);
      min_e7_q      <= min_sum[29:0];
      s2_q          <= s1_q;
      min_div_q     <= div_prod[57:34];
    end
  end

  // stage 3: field selection and sign handling
  always_comb begin
    val_d = '0;
    hi_d  = '0;
    mid_d = '0;
    lo_d  = '0;
    sub_d = '0;
    lat_d = lat_q;
    lon_d = lon_q;
    case (s2_q.code)
      FC_TIME: begin
        hi_d  = s2_q.high2;
        mid_d = s2_q.mid2;
        lo_d  = s2_q.low2;
        sub_d = s2_q.frac_raw;
      end
      FC_LAT: begin
        lat_d = s2_q.deg_e7 + ValW'(min_div_q);
        val_d = lat_d;
      end
      FC_NS: begin
        lat_d = s2_q.flag ? ValW'(-lat_q) : lat_q;
        val_d = lat_d;
      end
      FC_LON: begin
        lon_d = s2_q.deg_e7 + ValW'(min_div_q);
        val_d = lon_d;
      end
      FC_EW: begin
        lon_d = s2_q.flag ? ValW'(-lon_q) : lon_q;
        val_d = lon_d;
      end
      FC_FIX, FC_SATS: val_d = ValW'(s2_q.int_bin);
      FC_ALT: val_d = s2_q.minus ? ValW'(-s2_q.milli) : s2_q.milli;
      FC_SPEED, FC_COURSE: val_d = s2_q.milli;
      FC_DATE: begin
        hi_d  = s2_q.high2;
        mid_d = s2_q.mid2;
        lo_d  = s2_q.low2;
      end
      default: val_d = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      field_code_o    <= s2_q.code;
      sentence_kind_o <= s2_q.kind;
      fixed_value_o   <= val_d;
      part_high_o     <= hi_d;
      part_mid_o      <= mid_d;
      part_low_o      <= lo_d;
      sub_second_o    <= sub_d;
      flag_bit_o      <= s2_q.flag;
      fields_seen_o   <= s2_q.seen;
    end
  end

endmodule

@@ rtl/nmea_gga_rmc_field_parser_top.sv @@
// NMEA GGA/RMC field parser: takes one received character per cycle and emits
// one item per recognized field when its term closes (',' or '*'). The front
// end handles each character combinationally, so input is taken every cycle
// unless the 4-entry queue to the back end is full. The back end is a
// three-stage pipeline (products, divide by 60, selection into the output
// register); it moves one result per cycle when the output is not stalled.
// The seen mask clears before a character whenever it equals required_mask.
`include "nmea_gga_rmc_field_parser_top_assert.svh"
module nmea_gga_rmc_field_parser_top import ngrp_pkg::*; #(
  parameter int TERM_LIMIT  = 20,
  parameter int INT_DIGITS  = 9,
  parameter int FRAC_DIGITS = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [11:0]            required_mask_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             char_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [3:0]             field_code_o,
  output logic                   sentence_kind_o,
  output logic signed [ValW-1:0] fixed_value_o,
  output logic [6:0]             part_high_o,
  output logic [6:0]             part_mid_o,
  output logic [6:0]             part_low_o,
  output logic [23:0]            sub_second_o,
  output logic                   flag_bit_o,
  output logic [11:0]            fields_seen_o
);

  logic [11:0] req_mask_q;
  logic        acc, push, pop, q_valid, q_full;
  rec_t        push_rec, q_rec;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign acc         = in_valid_i && !q_full;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_mask_q <= '0;
    end else if (cfg_valid_i) begin
      req_mask_q <= required_mask_i;
    end
  end

  ngrp_front #(
    .TERM_LIMIT (TERM_LIMIT),
    .INT_DIGITS (INT_DIGITS),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .char_in_i (char_in_i),
    .req_mask_i(req_mask_q),
    .push_o    (push),
    .rec_o     (push_rec)
  );

  ngrp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_rec),
    .pop_i  (pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .data_o (q_rec)
  );

  ngrp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_rec),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .field_code_o   (field_code_o),
    .sentence_kind_o(sentence_kind_o),
    .fixed_value_o  (fixed_value_o),
    .part_high_o    (part_high_o),
    .part_mid_o     (part_mid_o),
    .part_low_o     (part_low_o),
    .sub_second_o   (sub_second_o),
    .flag_bit_o     (flag_bit_o),
    .fields_seen_o  (fields_seen_o)
  );

  // result sanity
  `NGRP_NEVER(a_code_range, clk_i, rst_ni, out_valid_o && field_code_o > FC_DATE)
  `NGRP_ASSERT(a_seen_has_code, clk_i, rst_ni, out_valid_o |-> fields_seen_o[field_code_o])
  `NGRP_NEVER(a_kind_code, clk_i, rst_ni, out_valid_o && (sentence_kind_o != (field_code_o >= FC_VALID)))

endmodule
